// ----- rtl/core/tou_pkg.sv -----
// Shared types and constants for the trackball orientation update block.
// Used by tou_divsqrt, trackball_orientation_update_top and tou_checker.
`default_nettype none

package tou_pkg;

	localparam int COORD_W    = 12;
	localparam int SIZE_W     = 13;
	localparam int QUAT_W     = 16;
	localparam int FRAC_W     = 14;
	localparam int LIFT_W     = 14;
	localparam int ONE        = 1 << FRAC_W;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 64;
	localparam int NUM_W      = 64;
	localparam int DEN_W      = 32;
	localparam int MUL_W      = 32;
	localparam int ACC_W      = 64;
	localparam int VEC_W      = 18;
	localparam int RAW_W      = 34;
	localparam int NM_W       = 30;
	localparam int LEN_W      = 31;
	localparam int DIV_STEPS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int CFG_ADDR_W = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic             start;
		logic             sqrt;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} unit_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] result;
	} unit_rsp_t;

	// Sign pattern of the Hamilton product: term j of output component i.
	function automatic logic ham_neg(input logic [1:0] i, input logic [1:0] j);
		logic [3:0] row;
		begin
			case (i)
				2'd0: row = 4'b1110;
				2'd1: row = 4'b1000;
				2'd2: row = 4'b0010;
				default: row = 4'b0100;
			endcase
			return row[j];
		end
	endfunction

	// Cross product terms: a[cross_a] * b[cross_b], odd terms subtracted.
	function automatic logic [1:0] cross_a(input logic [2:0] t);
		case (t)
			3'd0: return 2'd1;
			3'd1: return 2'd2;
			3'd2: return 2'd2;
			3'd3: return 2'd0;
			3'd4: return 2'd0;
			default: return 2'd1;
		endcase
	endfunction

	function automatic logic [1:0] cross_b(input logic [2:0] t);
		case (t)
			3'd0: return 2'd2;
			3'd1: return 2'd1;
			3'd2: return 2'd0;
			3'd3: return 2'd2;
			3'd4: return 2'd1;
			default: return 2'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tou_divsqrt.sv -----
// Shared iterative unit: unsigned restoring division (one bit a cycle) and
// integer square root (two radicand bits a cycle). Depends on tou_pkg.
`default_nettype none

module tou_divsqrt (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tou_pkg::unit_req_t req,
	output tou_pkg::unit_rsp_t      rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic                        sqrt_q;
	logic [6:0]                  cnt_q;
	logic [tou_pkg::NUM_W-1:0]   rad_q;
	logic [34:0]                 rem_q;
	logic [tou_pkg::NUM_W-1:0]   quo_q;
	logic [tou_pkg::DEN_W-1:0]   den_q;

	logic [34:0] t_val;
	logic [34:0] trial;
	logic        ge;
	logic        last;

	always_comb begin
		if (sqrt_q) begin
			t_val = {rem_q[32:0], rad_q[63:62]};
			trial = {1'b0, quo_q[31:0], 2'b01};
			last  = (cnt_q == 7'(tou_pkg::SQRT_STEPS - 1));
		end else begin
			t_val = {rem_q[33:0], rad_q[63]};
			trial = {3'b000, den_q};
			last  = (cnt_q == 7'(tou_pkg::DIV_STEPS - 1));
		end
		ge = (t_val >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sqrt_q <= req.sqrt;
			rad_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (t_val - trial) : t_val;
			quo_q <= {quo_q[62:0], ge};
			rad_q <= sqrt_q ? {rad_q[61:0], 2'b00} : {rad_q[62:0], 1'b0};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/trackball_orientation_update_top.sv -----
// Trackball orientation update: sequencer, multiplier and state registers.
// Depends on tou_pkg and tou_divsqrt.
//
// Usage: each word on the s_ channel is one mouse drag (start and end pixel).
// The block lifts both pixels onto the virtual trackball, forms the rotation
// between them, applies it to the stored orientation and sends the new
// orientation as one word on the m_ channel (w, x, y, z in Q.14).
// A drag whose two points are equal goes straight to the output state and
// returns the stored orientation unchanged. Any other drag runs the full
// lift, rotation and product sequence; when the rotation or the product has
// zero length, the identity is used instead. Fourteen divisions and five
// square roots on the shared unit dominate the processing time.
// s_tready is high only while the sequencer is idle, so one drag is processed
// at a time and the next one is taken only after the result is registered.
// The result sits in an output register; the next drag is accepted while it
// waits, and the sequencer holds its finished result until the register frees.
// The user must write screen size via cfg_we/cfg_addr/cfg_wdata only while idle;
// the block does not enforce it. A size of zero acts as one. Reset sets both
// sizes to one, the orientation to the identity, and clears the output register.
`default_nettype none

module trackball_orientation_update_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tou_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire logic [tou_pkg::SIZE_W-1:0]          cfg_wdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// start_x, start_y, end_x, end_y (12 bits each, lowest first)
	input  wire logic [tou_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// quat_w, quat_x, quat_y, quat_z (16 bits signed each, lowest first)
	output logic [tou_pkg::OUT_DATA_W-1:0]           m_tdata
);

	typedef enum logic [4:0] {
		S_IDLE, S_L_DIFF, S_L_SQ0, S_L_SQ1, S_L_MM, S_L_CLS,
		S_L_R_GO, S_L_R_WT, S_L_X_GO, S_L_X_WT, S_L_Y_GO, S_L_Y_WT,
		S_L_Z_GO, S_L_Z_WT, S_L_ZS_GO, S_L_ZS_WT,
		S_NA, S_NB, S_NN, S_RS_GO, S_RS_WT, S_DOT, S_CROSS,
		S_N_MAX, S_N_SUM, S_N_SQ_GO, S_N_SQ_WT, S_N_DIV_GO, S_N_DIV_WT,
		S_PM, S_PR, S_OUT
	} state_t;

	localparam int CW = tou_pkg::COORD_W;
	localparam int SW = tou_pkg::SIZE_W;
	localparam int DXW = tou_pkg::SIZE_W + 2;
	localparam int QW = tou_pkg::QUAT_W;

	state_t state_q;
	logic [3:0] idx_q;
	logic       pt_q;
	logic       nsel_q;
	logic       inside_q;

	logic [SW-1:0] width_q, height_q;
	logic [CW-1:0] sx_q, sy_q, ex_q, ey_q;

	logic signed [QW-1:0] ori_q [4];
	logic signed [QW-1:0] dq_q [4];
	logic signed [tou_pkg::VEC_W-1:0] va_q [3];
	logic signed [tou_pkg::VEC_W-1:0] vb_q [3];
	logic signed [tou_pkg::RAW_W-1:0] c_q [4];
	logic [tou_pkg::NM_W-1:0]  nm_q [4];

	logic signed [DXW-1:0] dx_q, dy_q;
	logic [SW-1:0]          m_q;
	logic [27:0]            s_q;
	logic [25:0]            mm_q;
	logic [tou_pkg::DEN_W-1:0] den_q;
	logic [30:0]            na_q, nb_q;
	logic [tou_pkg::LEN_W-1:0] len_q;
	logic signed [tou_pkg::ACC_W-1:0] acc_q;

	logic            m_tvalid_q;
	logic [tou_pkg::OUT_DATA_W-1:0] m_tdata_q;

	tou_pkg::unit_req_t ureq;
	tou_pkg::unit_rsp_t ursp;

	tou_divsqrt u_divsqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ureq),
		.rsp   (ursp)
	);

	// Lift inputs for the point being worked on.
	logic [CW-1:0] px, py;
	logic [SW-1:0] wv, hv;
	logic [1:0]    i2, j2, ca, cb;
	logic [2:0]    ct;
	logic [13:0]   mag_dx, mag_dy;
	logic [5:0]    sh;
	logic [25:0]   zdiff;

	always_comb begin
		px = pt_q ? ex_q : sx_q;
		py = pt_q ? ey_q : sy_q;
		wv = (width_q == '0) ? SW'(1) : width_q;
		hv = (height_q == '0) ? SW'(1) : height_q;
		i2 = idx_q[3:2];
		j2 = idx_q[1:0];
		ct = idx_q[2:0];
		ca = tou_pkg::cross_a(ct);
		cb = tou_pkg::cross_b(ct);
		mag_dx = 14'(dx_q[DXW-1] ? -dx_q : dx_q);
		mag_dy = 14'(dy_q[DXW-1] ? -dy_q : dy_q);
		sh = inside_q ? 6'(tou_pkg::LIFT_W) : 6'(2 * tou_pkg::LIFT_W);
		zdiff = 26'(mm_q - s_q[25:0]);
	end

	// Shared multiplier.
	logic signed [tou_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [tou_pkg::ACC_W-1:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_L_SQ0: begin
				mul_a = 32'(dx_q);
				mul_b = 32'(dx_q);
			end
			S_L_SQ1: begin
				mul_a = 32'(dy_q);
				mul_b = 32'(dy_q);
			end
			S_L_MM: begin
				mul_a = $signed(32'(m_q));
				mul_b = $signed(32'(m_q));
			end
			S_NA: begin
				mul_a = 32'(va_q[j2]);
				mul_b = 32'(va_q[j2]);
			end
			S_NB: begin
				mul_a = 32'(vb_q[j2]);
				mul_b = 32'(vb_q[j2]);
			end
			S_NN: begin
				mul_a = $signed(32'(na_q));
				mul_b = $signed(32'(nb_q));
			end
			S_DOT: begin
				mul_a = 32'(va_q[j2]);
				mul_b = 32'(vb_q[j2]);
			end
			S_CROSS: begin
				mul_a = ct[0] ? -32'(va_q[ca]) : 32'(va_q[ca]);
				mul_b = 32'(vb_q[cb]);
			end
			S_N_SUM: begin
				mul_a = $signed(32'(nm_q[j2]));
				mul_b = $signed(32'(nm_q[j2]));
			end
			S_PM: begin
				mul_a = tou_pkg::ham_neg(i2, j2) ? -32'(dq_q[j2]) : 32'(dq_q[j2]);
				mul_b = 32'(ori_q[i2 ^ j2]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;
	end

	// Operand selection for the shared divide/square-root unit.
	always_comb begin
		ureq = '0;
		case (state_q)
			S_L_R_GO: begin
				ureq.start = 1'b1;
				ureq.sqrt  = 1'b1;
				ureq.num   = 64'(s_q) << (2 * tou_pkg::LIFT_W);
			end
			S_L_X_GO: begin
				ureq.start = 1'b1;
				ureq.num   = (64'(mag_dx) << sh) + 64'(den_q >> 1);
				ureq.den   = den_q;
			end
			S_L_Y_GO: begin
				ureq.start = 1'b1;
				ureq.num   = (64'(mag_dy) << sh) + 64'(den_q >> 1);
				ureq.den   = den_q;
			end
			S_L_Z_GO: begin
				ureq.start = 1'b1;
				if (inside_q) begin
					ureq.num = 64'(zdiff) << (2 * tou_pkg::LIFT_W);
					ureq.den = 32'(mm_q);
				end else begin
					ureq.num = (64'(mm_q) << (tou_pkg::LIFT_W - 1)) + 64'(s_q >> 1);
					ureq.den = 32'(s_q);
				end
			end
			S_L_ZS_GO, S_RS_GO, S_N_SQ_GO: begin
				ureq.start = 1'b1;
				ureq.sqrt  = 1'b1;
				ureq.num   = acc_q;
			end
			S_N_DIV_GO: begin
				ureq.start = 1'b1;
				ureq.num   = (64'(nm_q[j2]) << tou_pkg::FRAC_W) + 64'(len_q >> 1);
				ureq.den   = 32'(len_q);
			end
			default: ureq = '0;
		endcase
	end

	// Magnitude scaling ahead of normalization: keep every magnitude below 2^30.
	logic [tou_pkg::RAW_W-1:0] cmag [4];
	logic [tou_pkg::RAW_W-1:0] mx;
	logic [2:0]                shift_k;

	always_comb begin
		mx = '0;
		for (int i = 0; i < 4; i++) begin
			cmag[i] = c_q[i][tou_pkg::RAW_W-1] ? tou_pkg::RAW_W'(-c_q[i])
			                                   : tou_pkg::RAW_W'(c_q[i]);
			if (cmag[i] > mx) begin
				mx = cmag[i];
			end
		end
		shift_k = 3'd4;
		for (int k = 4; k >= 0; k--) begin
			if ((mx >> k) < (tou_pkg::RAW_W'(1) << tou_pkg::NM_W)) begin
				shift_k = 3'(k);
			end
		end
	end

	// Quotient handling shared by the lift and normalization steps.
	logic signed [tou_pkg::VEC_W-1:0] qv;
	logic signed [tou_pkg::VEC_W-1:0] qv_x, qv_y;
	logic [QW-1:0]                    nsat;
	logic signed [QW-1:0]             nval;
	logic signed [tou_pkg::ACC_W-1:0] sum_next;

	always_comb begin
		qv   = $signed(ursp.result[tou_pkg::VEC_W-1:0]);
		qv_x = dx_q[DXW-1] ? -qv : qv;
		qv_y = dy_q[DXW-1] ? -qv : qv;
		nsat = (ursp.result > 64'(tou_pkg::ONE)) ? QW'(tou_pkg::ONE)
		                                         : ursp.result[QW-1:0];
		nval = c_q[j2][tou_pkg::RAW_W-1] ? -$signed(nsat) : $signed(nsat);
		sum_next = acc_q + prod;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			pt_q       <= 1'b0;
			nsel_q     <= 1'b0;
			inside_q   <= 1'b0;
			width_q    <= SW'(1);
			height_q   <= SW'(1);
			ori_q[0]   <= QW'(tou_pkg::ONE);
			ori_q[1]   <= '0;
			ori_q[2]   <= '0;
			ori_q[3]   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result may replace the word that leaves in this cycle.
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_addr)
					tou_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata;
					tou_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tdata[11:0] == s_tdata[35:24] &&
						    s_tdata[23:12] == s_tdata[47:36]) begin
							state_q <= S_OUT;
						end else begin
							pt_q    <= 1'b0;
							state_q <= S_L_DIFF;
						end
					end
				end
				S_L_DIFF: state_q <= S_L_SQ0;
				S_L_SQ0:  state_q <= S_L_SQ1;
				S_L_SQ1:  state_q <= S_L_MM;
				S_L_MM:   state_q <= S_L_CLS;
				S_L_CLS: begin
					inside_q <= ({s_q, 1'b0} < 29'(mm_q));
					state_q  <= ({s_q, 1'b0} < 29'(mm_q)) ? S_L_X_GO : S_L_R_GO;
				end
				S_L_R_GO: state_q <= S_L_R_WT;
				S_L_R_WT: begin
					if (ursp.done) begin
						state_q <= S_L_X_GO;
					end
				end
				S_L_X_GO: state_q <= S_L_X_WT;
				S_L_X_WT: begin
					if (ursp.done) begin
						state_q <= S_L_Y_GO;
					end
				end
				S_L_Y_GO: state_q <= S_L_Y_WT;
				S_L_Y_WT: begin
					if (ursp.done) begin
						state_q <= S_L_Z_GO;
					end
				end
				S_L_Z_GO: state_q <= S_L_Z_WT;
				S_L_Z_WT: begin
					if (ursp.done) begin
						if (inside_q) begin
							state_q <= S_L_ZS_GO;
						end else if (!pt_q) begin
							pt_q    <= 1'b1;
							state_q <= S_L_DIFF;
						end else begin
							idx_q   <= '0;
							state_q <= S_NA;
						end
					end
				end
				S_L_ZS_GO: state_q <= S_L_ZS_WT;
				S_L_ZS_WT: begin
					if (ursp.done) begin
						if (!pt_q) begin
							pt_q    <= 1'b1;
							state_q <= S_L_DIFF;
						end else begin
							idx_q   <= '0;
							state_q <= S_NA;
						end
					end
				end
				S_NA: begin
					if (idx_q == 4'd2) begin
						idx_q   <= '0;
						state_q <= S_NB;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_NB: begin
					if (idx_q == 4'd2) begin
						idx_q   <= '0;
						state_q <= S_NN;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_NN:    state_q <= S_RS_GO;
				S_RS_GO: state_q <= S_RS_WT;
				S_RS_WT: begin
					if (ursp.done) begin
						idx_q   <= '0;
						state_q <= S_DOT;
					end
				end
				S_DOT: begin
					if (idx_q == 4'd2) begin
						idx_q   <= '0;
						state_q <= S_CROSS;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_CROSS: begin
					if (idx_q == 4'd5) begin
						idx_q   <= '0;
						nsel_q  <= 1'b0;
						state_q <= S_N_MAX;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_N_MAX: begin
					idx_q   <= '0;
					state_q <= S_N_SUM;
				end
				S_N_SUM: begin
					if (idx_q == 4'd3) begin
						idx_q   <= '0;
						state_q <= S_N_SQ_GO;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_N_SQ_GO: state_q <= S_N_SQ_WT;
				S_N_SQ_WT: begin
					if (ursp.done) begin
						idx_q <= '0;
						if (ursp.result == '0) begin
							// Zero length: fall back to the identity.
							if (nsel_q) begin
								ori_q[0] <= QW'(tou_pkg::ONE);
								ori_q[1] <= '0;
								ori_q[2] <= '0;
								ori_q[3] <= '0;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_PM;
							end
						end else begin
							state_q <= S_N_DIV_GO;
						end
					end
				end
				S_N_DIV_GO: state_q <= S_N_DIV_WT;
				S_N_DIV_WT: begin
					if (ursp.done) begin
						if (nsel_q) begin
							ori_q[j2] <= nval;
						end
						if (idx_q == 4'd3) begin
							idx_q   <= '0;
							state_q <= nsel_q ? S_OUT : S_PM;
						end else begin
							idx_q   <= idx_q + 4'd1;
							state_q <= S_N_DIV_GO;
						end
					end
				end
				S_PM: begin
					if (idx_q == 4'd15) begin
						idx_q   <= '0;
						state_q <= S_PR;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				S_PR: begin
					nsel_q  <= 1'b1;
					state_q <= S_N_MAX;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sx_q <= s_tdata[11:0];
				sy_q <= s_tdata[23:12];
				ex_q <= s_tdata[35:24];
				ey_q <= s_tdata[47:36];
			end
			S_L_DIFF: begin
				dx_q <= $signed({2'b00, px, 1'b0}) - $signed({2'b00, wv});
				dy_q <= $signed({2'b00, hv}) - $signed({2'b00, py, 1'b0});
				m_q  <= (wv < hv) ? wv : hv;
			end
			S_L_SQ0: acc_q <= prod;
			S_L_SQ1: s_q <= 28'(sum_next);
			S_L_MM:  mm_q <= 26'(prod);
			S_L_CLS: den_q <= 32'(m_q);
			S_L_R_WT: begin
				if (ursp.done) begin
					den_q <= ursp.result[tou_pkg::DEN_W-1:0];
				end
			end
			S_L_X_WT: begin
				if (ursp.done) begin
					if (pt_q) vb_q[0] <= qv_x;
					else va_q[0] <= qv_x;
				end
			end
			S_L_Y_WT: begin
				if (ursp.done) begin
					if (pt_q) vb_q[1] <= qv_y;
					else va_q[1] <= qv_y;
				end
			end
			S_L_Z_WT: begin
				if (ursp.done) begin
					acc_q <= $signed(ursp.result);
					if (pt_q) vb_q[2] <= qv;
					else va_q[2] <= qv;
				end
			end
			S_L_ZS_WT: begin
				if (ursp.done) begin
					if (pt_q) vb_q[2] <= qv;
					else va_q[2] <= qv;
				end
			end
			S_NA: begin
				acc_q <= (idx_q == 4'd0) ? prod : sum_next;
				na_q  <= 31'(sum_next);
			end
			S_NB: begin
				acc_q <= (idx_q == 4'd0) ? prod : sum_next;
				nb_q  <= 31'(sum_next);
			end
			S_NN: acc_q <= prod;
			S_RS_WT: begin
				if (ursp.done) begin
					acc_q <= $signed(ursp.result);
				end
			end
			S_DOT: begin
				acc_q <= sum_next;
				if (idx_q == 4'd2) begin
					c_q[0] <= tou_pkg::RAW_W'(sum_next);
				end
			end
			S_CROSS: begin
				acc_q <= ct[0] ? sum_next : prod;
				if (ct[0]) begin
					c_q[2'(ct[2:1] + 2'd1)] <= tou_pkg::RAW_W'(sum_next);
				end
			end
			S_N_MAX: begin
				for (int i = 0; i < 4; i++) begin
					nm_q[i] <= tou_pkg::NM_W'(cmag[i] >> shift_k);
				end
			end
			S_N_SUM: acc_q <= (idx_q == 4'd0) ? prod : sum_next;
			S_N_SQ_WT: begin
				if (ursp.done) begin
					len_q <= ursp.result[tou_pkg::LEN_W-1:0];
					if (ursp.result == '0 && !nsel_q) begin
						dq_q[0] <= QW'(tou_pkg::ONE);
						dq_q[1] <= '0;
						dq_q[2] <= '0;
						dq_q[3] <= '0;
					end
				end
			end
			S_N_DIV_WT: begin
				if (ursp.done && !nsel_q) begin
					dq_q[j2] <= nval;
				end
			end
			S_PM: begin
				acc_q <= (j2 == 2'd0) ? prod : sum_next;
				if (j2 == 2'd3) begin
					c_q[i2] <= tou_pkg::RAW_W'(sum_next);
				end
			end
			S_PR: begin
				// Divide by one in Q.14, rounding halves away from zero.
				for (int i = 0; i < 4; i++) begin
					c_q[i] <= c_q[i][tou_pkg::RAW_W-1]
						? -$signed((cmag[i] + tou_pkg::RAW_W'(tou_pkg::ONE / 2))
						           >> tou_pkg::FRAC_W)
						: $signed((cmag[i] + tou_pkg::RAW_W'(tou_pkg::ONE / 2))
						          >> tou_pkg::FRAC_W);
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {ori_q[3], ori_q[2], ori_q[1], ori_q[0]};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/tou_checker.sv -----
// Port-level checks for the trackball orientation update block.
// Depends on tou_pkg; bound onto trackball_orientation_update_top.
`default_nettype none

module tou_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [tou_pkg::IN_DATA_W-1:0]   s_tdata,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [tou_pkg::OUT_DATA_W-1:0]  m_tdata
);

	// A drag word waiting for the block stays put until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("drag word changed while waiting");

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// One drag at a time: the block is busy right after taking a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a word");

	// Every component of a normalized quaternion lies within plus or minus one.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			$signed(m_tdata[15:0])  <= 16'sd16384 && $signed(m_tdata[15:0])  >= -16'sd16384 &&
			$signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384 &&
			$signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384 &&
			$signed(m_tdata[63:48]) <= 16'sd16384 && $signed(m_tdata[63:48]) >= -16'sd16384)
		else $error("quaternion component out of range");

endmodule

bind trackball_orientation_update_top tou_checker u_tou_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

// ----- tb/trackball_orientation_update_top_tb.sv -----
// Self-checking testbench for trackball_orientation_update_top: random and directed drags
// checked word by word against an internal fixed-point trackball predictor.
// Depends on tou_pkg and the RTL of the block.
`default_nettype none

module trackball_orientation_update_top_tb;

	typedef longint vec4_t [4];
	typedef longint vec3_t [3];

	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD   = 3000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tou_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [tou_pkg::SIZE_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [tou_pkg::IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [tou_pkg::OUT_DATA_W-1:0] m_tdata;

	logic [tou_pkg::IN_DATA_W-1:0] pending_drags[$];
	logic [tou_pkg::OUT_DATA_W-1:0] expected_quats[$];
	longint orient [4];
	longint width_px;
	longint height_px;
	int sender_idle_pct;
	int recv_stall_pct;
	int errors;
	int quiet_cycles;
	int hold_cnt;
	bit hold_start;
	bit hold_taken;
	bit drag_taken;

	trackball_orientation_update_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint div_nearest(input longint num, input longint unsigned den);
		longint unsigned q;
		q = (magnitude(num) + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	// Scales a 4-vector to length ONE; returns 0 when its length is zero.
	function automatic bit unit_length(input vec4_t c, output vec4_t res);
		longint unsigned mx, sum, len;
		longint unsigned m [4];
		longint v;
		int k;
		mx = 0;
		sum = 0;
		k = 0;
		for (int i = 0; i < 4; i++) begin
			m[i] = magnitude(c[i]);
			if (m[i] > mx) mx = m[i];
		end
		while ((mx >> k) >= (64'd1 << 30)) k++;
		for (int i = 0; i < 4; i++) begin
			m[i] = m[i] >> k;
			sum += m[i] * m[i];
		end
		len = isqrt(sum);
		for (int i = 0; i < 4; i++) res[i] = 0;
		if (len == 0) return 1'b0;
		for (int i = 0; i < 4; i++) begin
			v = div_nearest(longint'(m[i]) * tou_pkg::ONE, len);
			if (v > tou_pkg::ONE) v = tou_pkg::ONE;
			res[i] = c[i] < 0 ? -v : v;
		end
		return 1'b1;
	endfunction

	// Inside the ball the point goes onto the sphere, outside onto the hyperbolic sheet.
	function automatic void lift_pixel(input longint px, input longint py, output vec3_t v);
		longint m, dx, dy;
		longint unsigned s, mm, r;
		m = width_px < height_px ? width_px : height_px;
		dx = 2 * px - width_px;
		dy = height_px - 2 * py;
		s = dx * dx + dy * dy;
		mm = m * m;
		if (2 * s < mm) begin
			v[0] = div_nearest(dx * (64'sd1 <<< tou_pkg::LIFT_W), m);
			v[1] = div_nearest(dy * (64'sd1 <<< tou_pkg::LIFT_W), m);
			v[2] = isqrt(((mm - s) << (2 * tou_pkg::LIFT_W)) / mm);
		end else begin
			r = isqrt(s << (2 * tou_pkg::LIFT_W));
			v[0] = div_nearest(dx * (64'sd1 <<< (2 * tou_pkg::LIFT_W)), r);
			v[1] = div_nearest(dy * (64'sd1 <<< (2 * tou_pkg::LIFT_W)), r);
			v[2] = div_nearest(longint'(mm << (tou_pkg::LIFT_W - 1)), s);
		end
	endfunction

	function automatic logic [tou_pkg::OUT_DATA_W-1:0] apply_drag(
			input logic [tou_pkg::IN_DATA_W-1:0] d);
		longint x1, y1, x2, y2;
		longint unsigned na, nb;
		vec3_t a, b;
		vec4_t raw, dq, p, o, nq;
		x1 = d[11:0];
		y1 = d[23:12];
		x2 = d[35:24];
		y2 = d[47:36];
		if (x1 != x2 || y1 != y2) begin
			for (int i = 0; i < 4; i++) o[i] = orient[i];
			lift_pixel(x1, y1, a);
			lift_pixel(x2, y2, b);
			na = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
			nb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
			raw[0] = longint'(isqrt(na * nb)) + a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
			raw[1] = a[1] * b[2] - a[2] * b[1];
			raw[2] = a[2] * b[0] - a[0] * b[2];
			raw[3] = a[0] * b[1] - a[1] * b[0];
			// Nearly opposite directions give no usable rotation: keep still.
			if (!unit_length(raw, dq)) begin
				dq[0] = tou_pkg::ONE;
				dq[1] = 0;
				dq[2] = 0;
				dq[3] = 0;
			end
			p[0] = dq[0] * o[0] - dq[1] * o[1] - dq[2] * o[2] - dq[3] * o[3];
			p[1] = dq[0] * o[1] + dq[1] * o[0] + dq[2] * o[3] - dq[3] * o[2];
			p[2] = dq[0] * o[2] - dq[1] * o[3] + dq[2] * o[0] + dq[3] * o[1];
			p[3] = dq[0] * o[3] + dq[1] * o[2] - dq[2] * o[1] + dq[3] * o[0];
			for (int i = 0; i < 4; i++) p[i] = div_nearest(p[i], tou_pkg::ONE);
			if (!unit_length(p, nq)) begin
				nq[0] = tou_pkg::ONE;
				nq[1] = 0;
				nq[2] = 0;
				nq[3] = 0;
			end
			for (int i = 0; i < 4; i++) orient[i] = nq[i];
		end
		return {orient[3][15:0], orient[2][15:0], orient[1][15:0], orient[0][15:0]};
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Monitor, predictor and watchdog, all on the rising edge.
	always @(posedge clk) begin
		logic [tou_pkg::OUT_DATA_W-1:0] want;
		drag_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) expected_quats.push_back(apply_drag(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_quats.size() == 0) begin
					report_mismatch("unexpected word, quat_w", $signed(m_tdata[15:0]), 0);
				end else begin
					want = expected_quats.pop_front();
					if (m_tdata[15:0] != want[15:0])
						report_mismatch("quat_w", $signed(m_tdata[15:0]), $signed(want[15:0]));
					if (m_tdata[31:16] != want[31:16])
						report_mismatch("quat_x", $signed(m_tdata[31:16]), $signed(want[31:16]));
					if (m_tdata[47:32] != want[47:32])
						report_mismatch("quat_y", $signed(m_tdata[47:32]), $signed(want[47:32]));
					if (m_tdata[63:48] != want[63:48])
						report_mismatch("quat_z", $signed(m_tdata[63:48]), $signed(want[63:48]));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Drag driver: holds a word until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || drag_taken) begin
			if (pending_drags.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_drags.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off to back the block up.
	always @(negedge clk) begin
		if (hold_start && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cnt <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [tou_pkg::IN_DATA_W-1:0] drag(input int sx, input int sy,
			input int ex, input int ey);
		return {ey[11:0], ex[11:0], sy[11:0], sx[11:0]};
	endfunction

	// Checked on the rising edge, where the driver and the monitor have settled.
	task automatic wait_drained();
		while (pending_drags.size() != 0 || expected_quats.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_size(input logic [tou_pkg::CFG_ADDR_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value[tou_pkg::SIZE_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == tou_pkg::REG_SCREEN_WIDTH) width_px = value == 0 ? 1 : value;
		else height_px = value == 0 ? 1 : value;
	endtask

	task automatic queue_random(input int count);
		int sx, sy, ex, ey;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				sx = $urandom_range(4095);
				sy = $urandom_range(4095);
			end else begin
				sx = $urandom_range(width_px > 4096 ? 4095 : width_px - 1);
				sy = $urandom_range(height_px > 4096 ? 4095 : height_px - 1);
			end
			case ($urandom_range(9))
				0, 1: begin
					ex = sx;
					ey = sy;
				end
				2, 3: begin
					ex = $urandom_range(4095);
					ey = $urandom_range(4095);
				end
				default: begin
					ex = (sx + $urandom_range(64) - 32) & 12'hfff;
					ey = (sy + $urandom_range(64) - 32) & 12'hfff;
				end
			endcase
			pending_drags.push_back(drag(sx, sy, ex, ey));
		end
	endtask

	initial begin
		int widths [6] = '{640, 0, 4096, 1, 4096, 1023};
		int heights [6] = '{480, 0, 4096, 4096, 1, 777};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_start = 1'b0;
		hold_taken = 1'b0;
		hold_cnt = 0;
		drag_taken = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		width_px = 1;
		height_px = 1;
		orient[0] = tou_pkg::ONE;
		orient[1] = 0;
		orient[2] = 0;
		orient[3] = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Default sizes of one straight out of reset.
		pending_drags.push_back(drag(0, 0, 1, 1));
		pending_drags.push_back(drag(5, 5, 5, 5));
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			write_size(tou_pkg::REG_SCREEN_WIDTH, widths[ph]);
			write_size(tou_pkg::REG_SCREEN_HEIGHT, heights[ph]);
			case (ph % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin sender_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			if (ph == 0) begin
				pending_drags.push_back(drag(320, 240, 320, 240));
				pending_drags.push_back(drag(0, 0, 0, 0));
				pending_drags.push_back(drag(4095, 4095, 4095, 4095));
				pending_drags.push_back(drag(320, 240, 400, 240));
				pending_drags.push_back(drag(320, 240, 320, 100));
				pending_drags.push_back(drag(0, 0, 639, 479));
				pending_drags.push_back(drag(0, 0, 4095, 4095));
				pending_drags.push_back(drag(4095, 0, 0, 4095));
				pending_drags.push_back(drag(100, 240, 540, 240));
				pending_drags.push_back(drag(2730, 1365, 1365, 2730));
				pending_drags.push_back(drag(320, 0, 320, 479));
				pending_drags.push_back(drag(319, 240, 321, 240));
			end else if (ph == 1) begin
				// Far points on opposite sides: rotation quaternion collapses.
				pending_drags.push_back(drag(0, 0, 4095, 0));
				pending_drags.push_back(drag(0, 4095, 4095, 0));
				pending_drags.push_back(drag(4095, 4095, 0, 0));
				pending_drags.push_back(drag(0, 2048, 4095, 2048));
			end
			if (ph == 2) begin
				hold_start = 1'b1;
				queue_random(20);
				wait_drained();
			end
			queue_random(70);
			// Let the sender wait for every result before continuing.
			wait_drained();
			queue_random(70);
			wait_drained();
		end

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/tou_pkg.sv
rtl/core/tou_divsqrt.sv
rtl/core/trackball_orientation_update_top.sv
rtl/core/tou_checker.sv
tb/trackball_orientation_update_top_tb.sv
